>>> design/fmvg_pkg.sv
// Shared widths, register codes and status types of the frustum vertex generator.
package fmvg_pkg;
	localparam int MAX_SEGMENTS = 256;
	localparam int RES_W = 9;
	localparam int LEN_W = 16;
	localparam int COLOR_W = 8;
	localparam int IDX_W = 11;
	localparam int POS_W = 17;
	localparam int NRM_W = 16;
	localparam int PHASE_W = 32;
	localparam int REM_W = 9;
	localparam int J_W = 8;
	localparam int TRIG_W = 32;
	localparam int FAC_W = 31;
	localparam int SIN_LAT = 20;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RESOLUTION    = 3'd0,
		REG_TOP_RADIUS    = 3'd1,
		REG_BOTTOM_RADIUS = 3'd2,
		REG_HEIGHT        = 3'd3,
		REG_RED           = 3'd4,
		REG_GREEN         = 3'd5,
		REG_BLUE          = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic             busy;
		logic [FAC_W-1:0] c;
	} fmvg_sf_t;
endpackage

>>> design/fmvg_div_cell.sv
// One restoring division cell of the phase divider chain: one quotient bit per cell.
module fmvg_div_cell
	import fmvg_pkg::*;
(
	input  logic               clk,
	input  logic               en,
	input  logic [RES_W-1:0]   n,
	input  logic               bit_in,
	input  logic [REM_W-1:0]   rem_in,
	input  logic [PHASE_W-1:0] quo_in,
	output logic [REM_W-1:0]   rem_q,
	output logic [PHASE_W-1:0] quo_q
);
	logic [REM_W:0] trial;
	logic           take;

	assign trial = {rem_in, bit_in};
	assign take  = trial >= {1'b0, n};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= REM_W'(take ? trial - {1'b0, n} : trial);
			quo_q <= {quo_in[PHASE_W-2:0], take};
		end
	end
endmodule

>>> design/fmvg_sin.sv
// Pipelined sine of a turn fraction: quarter-wave fold, Horner polynomial, Q30 result.
module fmvg_sin
	import fmvg_pkg::*;
(
	input  logic                     clk,
	input  logic                     en,
	input  logic [PHASE_W-1:0]       phase,
	output logic signed [TRIG_W-1:0] value_q
);
	localparam int STEPS = 5;
	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
	localparam logic [30:0] ONE = 31'h4000_0000;

	typedef struct packed {
		logic [30:0] x;
		logic [31:0] x2;
		logic        neg;
	} carry_t;

	function automatic int unsigned horner_d(input int i);
		case (i)
			0:       return 110;
			1:       return 72;
			2:       return 42;
			3:       return 20;
			default: return 6;
		endcase
	endfunction

	logic [30:0] q_s1;
	logic        neg_s1;
	logic [30:0] x_s2;
	logic        neg_s2;
	logic [31:0] x2_s3;
	logic [30:0] x_s3;
	logic        neg_s3;
	logic [63:0] qp;
	logic [61:0] xx;

	carry_t      cr_q [STEPS];
	logic [30:0] t_q  [STEPS];

	assign qp = {33'd0, q_s1} * TWO_PI_Q30;
	assign xx = {31'd0, x_s2} * {31'd0, x_s2};

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1   <= phase[30] ? ONE - {1'b0, phase[29:0]} : {1'b0, phase[29:0]};
			neg_s1 <= phase[31];
			x_s2   <= qp[62:32];
			neg_s2 <= neg_s1;
			x2_s3  <= xx[61:30];
			x_s3   <= x_s2;
			neg_s3 <= neg_s2;
		end
	end

	// each step: t = ONE - ((x2*t) >> 30) / D, D by reciprocal and one correction
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam int unsigned D = horner_d(i);
		localparam logic [63:0] M = (64'd1 << 33) / 64'(D);

		carry_t      cr_in;
		logic [30:0] t_in;
		logic [62:0] prod_m;
		logic [63:0] prod_r;
		logic [32:0] v_s1;
		carry_t      cr_s1;
		logic [32:0] v_s2;
		logic [30:0] q0_s2;
		carry_t      cr_s2;
		logic [32:0] rem;
		logic [30:0] quo;

		if (i == 0) begin : g_first
			assign cr_in = '{x: x_s3, x2: x2_s3, neg: neg_s3};
			assign t_in  = ONE;
		end else begin : g_next
			assign cr_in = cr_q[i-1];
			assign t_in  = t_q[i-1];
		end

		assign prod_m = {32'd0, t_in} * {31'd0, cr_in.x2};
		assign prod_r = {31'd0, v_s1} * {33'd0, M[30:0]};
		assign rem    = v_s2 - ({2'd0, q0_s2} * 33'(D));
		assign quo    = (rem >= 33'(D)) ? q0_s2 + 31'd1 : q0_s2;

		always_ff @(posedge clk) begin
			if (en) begin
				v_s1    <= prod_m[62:30];
				cr_s1   <= cr_in;
				v_s2    <= v_s1;
				q0_s2   <= prod_r[63:33];
				cr_s2   <= cr_s1;
				t_q[i]  <= ONE - quo;
				cr_q[i] <= cr_s2;
			end
		end
	end

	logic [61:0] sp_full;
	logic [31:0] sp_s1;
	logic        negf_s1;
	logic [31:0] mag;

	assign sp_full = {31'd0, cr_q[STEPS-1].x} * {31'd0, t_q[STEPS-1]};
	assign mag     = (sp_s1 > {1'b0, ONE}) ? {1'b0, ONE} : sp_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s1   <= sp_full[61:30];
			negf_s1 <= cr_q[STEPS-1].neg;
			value_q <= negf_s1 ? -$signed(mag) : $signed(mag);
		end
	end
endmodule

>>> design/fmvg_side.sv
// Side normal factor L/sqrt(L^2+d^2) in Q30, recomputed after every register write.
module fmvg_side
	import fmvg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [LEN_W-1:0] height,
	input  logic [LEN_W-1:0] top_radius,
	input  logic [LEN_W-1:0] bottom_radius,
	output fmvg_sf_t         status
);
	typedef enum logic [1:0] {ST_LOAD, ST_DIV, ST_ROOT, ST_DONE} state_t;

	state_t      state_q;
	logic [5:0]  cnt_q;
	logic [59:0] num_q;
	logic [32:0] den_q;
	logic [32:0] rem_q;
	logic [28:0] quo_q;
	logic [62:0] val_q;
	logic [62:0] res_q;
	logic [62:0] bit_q;
	logic [FAC_W-1:0] c_q;

	logic [31:0]        l2;
	logic signed [16:0] dif;
	logic signed [33:0] dsq;
	logic [32:0]        den;
	logic [33:0]        trial;
	logic               take;
	logic [28:0]        quo_nx;
	logic [63:0]        rsum;
	logic               rtake;
	logic [62:0]        res_nx;

	assign l2     = height * height;
	assign dif    = $signed({1'b0, bottom_radius}) - $signed({1'b0, top_radius});
	assign dsq    = dif * dif;
	assign den    = {1'b0, l2} + {1'b0, dsq[31:0]};
	assign trial  = {rem_q, num_q[59]};
	assign take   = trial >= {1'b0, den_q};
	assign quo_nx = {quo_q[27:0], take};
	assign rsum   = {1'b0, res_q} + {1'b0, bit_q};
	assign rtake  = {1'b0, val_q} >= rsum;
	assign res_nx = rtake ? (res_q >> 1) + bit_q : res_q >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			num_q   <= '0;
			den_q   <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			val_q   <= '0;
			res_q   <= '0;
			bit_q   <= '0;
			c_q     <= '0;
		end else if (start) begin
			state_q <= ST_LOAD;
		end else begin
			case (state_q)
				ST_LOAD: begin
					num_q <= {l2, 28'd0};
					den_q <= den;
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= 6'd59;
					if (den == '0) begin
						c_q     <= '0;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= 33'(take ? trial - {1'b0, den_q} : trial);
					num_q <= num_q << 1;
					quo_q <= quo_nx;
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) begin
						val_q   <= {2'd0, quo_nx, 32'd0};
						res_q   <= '0;
						bit_q   <= 63'd1 << 62;
						cnt_q   <= 6'd31;
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (rtake)
						val_q <= val_q - rsum[62:0];
					res_q <= res_nx;
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) begin
						c_q     <= res_nx[FAC_W-1:0];
						state_q <= ST_DONE;
					end
				end
				default: ;
			endcase
		end
	end

	assign status.busy = state_q != ST_DONE;
	assign status.c    = c_q;
endmodule

>>> design/frustum_mesh_vertex_generator.sv
// Frustum vertex generator top level: registers, index decode, phase chain, trig, output.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | to block  | in_valid / in_stall  | vertex_index
//  out     | from block| out_valid / out_stall| pos_*, normal_*, red/green/blue, flags
//  cfg     | to block  | cfg_write            | cfg_index, cfg_data
//
// One vertex per cycle while the output item is not stalled and the side factor unit is idle;
// a taken item passes the decode stage, 32 divider cells for the phase, 20 sine stages,
// a scaling stage and the output register.
// The whole pipeline moves together and holds while the output item is stalled.
// After reset and after any register write the side factor unit runs (square, 60 divide steps,
// 32 root steps) with in_stall held high.
module frustum_mesh_vertex_generator
	import fmvg_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [IDX_W-1:0]        vertex_index,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y,
	output logic signed [POS_W-1:0] pos_z,
	output logic signed [NRM_W-1:0] normal_x,
	output logic signed [NRM_W-1:0] normal_y,
	output logic signed [NRM_W-1:0] normal_z,
	output logic [COLOR_W-1:0]      red,
	output logic [COLOR_W-1:0]      green,
	output logic [COLOR_W-1:0]      blue,
	output logic                    index_error,
	output logic                    last_vertex,
	input  logic                    cfg_write,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);
	localparam int LINE = PHASE_W + SIN_LAT + 2;
	localparam logic signed [NRM_W-1:0] NRM_ONE = 16'sd16384;

	typedef struct packed {
		logic err;
		logic last;
		logic centre;
		logic top;
		logic wall;
	} item_t;

	logic [RES_W-1:0]   res_q;
	logic [LEN_W-1:0]   top_q;
	logic [LEN_W-1:0]   bot_q;
	logic [LEN_W-1:0]   height_q;
	logic [COLOR_W-1:0] red_q;
	logic [COLOR_W-1:0] green_q;
	logic [COLOR_W-1:0] blue_q;
	fmvg_sf_t           side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q    <= 9'd16;
			top_q    <= 16'd256;
			bot_q    <= 16'd256;
			height_q <= 16'd512;
			red_q    <= 8'd255;
			green_q  <= 8'd255;
			blue_q   <= 8'd255;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_RESOLUTION:    res_q    <= cfg_data[RES_W-1:0];
				REG_TOP_RADIUS:    top_q    <= cfg_data[LEN_W-1:0];
				REG_BOTTOM_RADIUS: bot_q    <= cfg_data[LEN_W-1:0];
				REG_HEIGHT:        height_q <= cfg_data[LEN_W-1:0];
				REG_RED:           red_q    <= cfg_data[COLOR_W-1:0];
				REG_GREEN:         green_q  <= cfg_data[COLOR_W-1:0];
				REG_BLUE:          blue_q   <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	fmvg_side u_side (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (cfg_write),
		.height       (height_q),
		.top_radius   (top_q),
		.bottom_radius(bot_q),
		.status       (side)
	);

	logic adv;
	logic acc;
	logic out_valid_q;

	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv || side.busy;
	assign acc      = in_valid && !in_stall;

	// index decode
	logic [RES_W-1:0] n_eff;
	logic [IDX_W-1:0] last_k;
	logic [IDX_W-1:0] n1;
	logic [IDX_W-1:0] n2;
	logic [IDX_W-1:0] n3;
	logic [IDX_W-1:0] km1;
	logic [IDX_W-1:0] base;
	logic [1:0]       seg;
	item_t            front;

	always_comb begin
		if (res_q == '0)
			n_eff = RES_W'(1);
		else if (res_q > RES_W'(MAX_SEGMENTS))
			n_eff = RES_W'(MAX_SEGMENTS);
		else
			n_eff = res_q;
		n1     = IDX_W'(n_eff);
		n2     = IDX_W'({n_eff, 1'b0});
		n3     = n2 + n1;
		last_k = IDX_W'({n_eff, 2'b00}) + IDX_W'(1);
		km1    = vertex_index - IDX_W'(1);
		if (km1 < n1) begin
			seg  = 2'd0;
			base = '0;
		end else if (km1 < n2) begin
			seg  = 2'd1;
			base = n1;
		end else if (km1 < n3) begin
			seg  = 2'd2;
			base = n2;
		end else begin
			seg  = 2'd3;
			base = n3;
		end
		front.err    = vertex_index > last_k;
		front.last   = vertex_index == last_k;
		front.centre = (vertex_index == '0) || (vertex_index == last_k);
		front.top    = vertex_index <= n2;
		front.wall   = (seg == 2'd1) || (seg == 2'd2);
	end

	logic [LINE-1:0] vld_q;
	item_t           item_q [LINE];
	logic [J_W-1:0]  j_s1;
	logic [IDX_W-1:0] jfull;

	assign jfull = km1 - base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[LINE-2:0], acc};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_q[0] <= front;
			j_s1      <= jfull[J_W-1:0];
			for (int i = 1; i < LINE; i++)
				item_q[i] <= item_q[i-1];
		end
	end

	// phase = (j * 2^32 + N/2) / N, one quotient bit per cell
	logic [J_W-1:0]     half_n;
	logic [REM_W-1:0]   rem_c [PHASE_W];
	logic [PHASE_W-1:0] quo_c [PHASE_W];
	logic [PHASE_W-1:0] bit_c;

	assign half_n = n_eff[RES_W-1:1];

	for (genvar i = 0; i < PHASE_W; i++) begin : g_cell
		logic [REM_W-1:0]   rem_in;
		logic [PHASE_W-1:0] quo_in;

		if (PHASE_W - 1 - i < J_W) begin : g_bit
			assign bit_c[i] = half_n[PHASE_W-1-i];
		end else begin : g_zero
			assign bit_c[i] = 1'b0;
		end
		if (i == 0) begin : g_head
			assign rem_in = {1'b0, j_s1};
			assign quo_in = '0;
		end else begin : g_link
			assign rem_in = rem_c[i-1];
			assign quo_in = quo_c[i-1];
		end

		fmvg_div_cell u_cell (
			.clk   (clk),
			.en    (adv),
			.n     (n_eff),
			.bit_in(bit_c[i]),
			.rem_in(rem_in),
			.quo_in(quo_in),
			.rem_q (rem_c[i]),
			.quo_q (quo_c[i])
		);
	end

	logic signed [TRIG_W-1:0] cos_v;
	logic signed [TRIG_W-1:0] sin_v;

	fmvg_sin u_cos (
		.clk    (clk),
		.en     (adv),
		.phase  (quo_c[PHASE_W-1] + 32'h4000_0000),
		.value_q(cos_v)
	);

	fmvg_sin u_sin (
		.clk    (clk),
		.en     (adv),
		.phase  (quo_c[PHASE_W-1]),
		.value_q(sin_v)
	);

	// scaling
	logic [30:0]      cabs;
	logic [30:0]      sabs;
	logic [LEN_W-1:0] r_mul;
	logic [46:0]      pxm_q;
	logic [46:0]      pzm_q;
	logic [61:0]      nxm_q;
	logic [61:0]      nzm_q;
	logic             cneg_q;
	logic             sneg_q;

	assign cabs  = cos_v[TRIG_W-1] ? 31'(-cos_v) : cos_v[30:0];
	assign sabs  = sin_v[TRIG_W-1] ? 31'(-sin_v) : sin_v[30:0];
	assign r_mul = item_q[LINE-2].top ? top_q : bot_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			pxm_q  <= {16'd0, cabs} * {31'd0, r_mul};
			pzm_q  <= {16'd0, sabs} * {31'd0, r_mul};
			nxm_q  <= {31'd0, cabs} * {31'd0, side.c};
			nzm_q  <= {31'd0, sabs} * {31'd0, side.c};
			cneg_q <= cos_v[TRIG_W-1];
			sneg_q <= sin_v[TRIG_W-1];
		end
	end

	// output assembly
	item_t                    it;
	logic [46:0]              pxr;
	logic [46:0]              pzr;
	logic [61:0]              nxr;
	logic [61:0]              nzr;
	logic [POS_W-1:0]         hsum;
	logic signed [POS_W-1:0]  h;
	logic                     rzero;
	logic signed [POS_W-1:0]  px_n, py_n, pz_n;
	logic signed [NRM_W-1:0]  nx_n, ny_n, nz_n;
	logic [COLOR_W-1:0]       red_n, green_n, blue_n;
	logic                     err_n, last_n;

	assign it    = item_q[LINE-1];
	assign pxr   = pxm_q + (47'd1 << 29);
	assign pzr   = pzm_q + (47'd1 << 29);
	assign nxr   = nxm_q + (62'd1 << 45);
	assign nzr   = nzm_q + (62'd1 << 45);
	assign hsum  = {1'b0, height_q} + POS_W'(1);
	assign h     = $signed({1'b0, hsum[POS_W-1:1]});
	assign rzero = (it.top ? top_q : bot_q) == '0;

	always_comb begin
		px_n    = '0;
		py_n    = '0;
		pz_n    = '0;
		nx_n    = '0;
		ny_n    = '0;
		nz_n    = '0;
		red_n   = '0;
		green_n = '0;
		blue_n  = '0;
		err_n   = 1'b0;
		last_n  = 1'b0;
		if (it.err) begin
			err_n = 1'b1;
		end else begin
			py_n    = it.top ? h : -h;
			ny_n    = it.top ? NRM_ONE : -NRM_ONE;
			red_n   = red_q;
			green_n = green_q;
			blue_n  = blue_q;
			last_n  = it.last;
			if (!it.centre) begin
				px_n = cneg_q ? -$signed(pxr[46:30]) : $signed(pxr[46:30]);
				pz_n = sneg_q ? -$signed(pzr[46:30]) : $signed(pzr[46:30]);
				if (it.wall) begin
					ny_n = '0;
					if (!rzero) begin
						nx_n = cneg_q ? -$signed(nxr[61:46]) : $signed(nxr[61:46]);
						nz_n = sneg_q ? -$signed(nzr[61:46]) : $signed(nzr[61:46]);
					end
				end
			end
		end
	end

	logic signed [POS_W-1:0] px_q, py_q, pz_q;
	logic signed [NRM_W-1:0] nx_q, ny_q, nz_q;
	logic [COLOR_W-1:0]      red_o_q, green_o_q, blue_o_q;
	logic                    err_q, last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= vld_q[LINE-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_q      <= px_n;
			py_q      <= py_n;
			pz_q      <= pz_n;
			nx_q      <= nx_n;
			ny_q      <= ny_n;
			nz_q      <= nz_n;
			red_o_q   <= red_n;
			green_o_q <= green_n;
			blue_o_q  <= blue_n;
			err_q     <= err_n;
			last_q    <= last_n;
		end
	end

	assign out_valid   = out_valid_q;
	assign pos_x       = px_q;
	assign pos_y       = py_q;
	assign pos_z       = pz_q;
	assign normal_x    = nx_q;
	assign normal_y    = ny_q;
	assign normal_z    = nz_q;
	assign red         = red_o_q;
	assign green       = green_o_q;
	assign blue        = blue_o_q;
	assign index_error = err_q;
	assign last_vertex = last_q;
endmodule

>>> tb/tb_frustum_mesh_vertex_generator.sv
// Self-checking testbench for the frustum vertex generator: random stimulus, scoreboard, watchdog.
`timescale 1ns / 1ps

module tb_frustum_mesh_vertex_generator;
	import fmvg_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;   // not decoded by the block
	localparam longint unsigned Q30_ONE = 64'd1 << 30;
	localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
	localparam int NORM_ONE = 16384;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 80;

	typedef struct {
		logic signed [POS_W-1:0] px, py, pz;
		logic signed [NRM_W-1:0] nx, ny, nz;
		logic [COLOR_W-1:0]      r, g, b;
		logic                    err, last;
	} vertex_t;

	class vertex_scoreboard;
		longint unsigned res, top_r, bot_r, len, cr, cg, cb;
		vertex_t pending_vertices[$];
		int mismatches;

		function new();
			res = 16; top_r = 256; bot_r = 256; len = 512;
			cr = 255; cg = 255; cb = 255;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				REG_RESOLUTION:    res = d & 16'h1FF;
				REG_TOP_RADIUS:    top_r = d;
				REG_BOTTOM_RADIUS: bot_r = d;
				REG_HEIGHT:        len = d;
				REG_RED:           cr = d & 16'hFF;
				REG_GREEN:         cg = d & 16'hFF;
				REG_BLUE:          cb = d & 16'hFF;
				default: ;
			endcase
		endfunction

		function longint unsigned segments();
			if (res < 1) return 1;
			if (res > MAX_SEGMENTS) return MAX_SEGMENTS;
			return res;
		endfunction

		function longint unsigned quarter_sine(longint unsigned q);
			longint unsigned x, x2, t, s;
			x = (q * TWO_PI_Q30) >> 32;
			x2 = (x * x) >> 30;
			t = Q30_ONE - x2 / 110;
			t = Q30_ONE - ((x2 * t) >> 30) / 72;
			t = Q30_ONE - ((x2 * t) >> 30) / 42;
			t = Q30_ONE - ((x2 * t) >> 30) / 20;
			t = Q30_ONE - ((x2 * t) >> 30) / 6;
			s = (x * t) >> 30;
			return (s > Q30_ONE) ? Q30_ONE : s;
		endfunction

		function longint turn_sine(logic [31:0] p);
			longint unsigned f, m;
			f = p[29:0];
			m = p[30] ? quarter_sine(Q30_ONE - f) : quarter_sine(f);
			return p[31] ? -longint'(m) : longint'(m);
		endfunction

		function longint round_scaled(longint v, longint unsigned m, int sh);
			longint unsigned mag, r;
			mag = (v < 0) ? longint'(-v) : v;
			r = (mag * m + (64'd1 << (sh - 1))) >> sh;
			return (v < 0) ? -longint'(r) : longint'(r);
		endfunction

		function longint unsigned floor_root(longint unsigned v);
			longint unsigned acc, bitv;
			acc = 0;
			bitv = 64'd1 << 62;
			while (bitv > v) bitv >>= 2;
			while (bitv != 0) begin
				if (v >= acc + bitv) begin
					v -= acc + bitv;
					acc = (acc >> 1) + bitv;
				end else begin
					acc >>= 1;
				end
				bitv >>= 2;
			end
			return acc;
		endfunction

		// cosine of the side slope, Q30
		function longint unsigned slope_factor();
			longint unsigned l2, d2, den;
			longint d;
			l2 = len * len;
			d = longint'(bot_r) - longint'(top_r);
			d2 = d * d;
			den = l2 + d2;
			if (den == 0) return 0;
			return floor_root(((l2 << 28) / den) << 32);
		endfunction

		function vertex_t vertex_at(longint unsigned k);
			vertex_t v;
			longint unsigned n, last, seg, j, r;
			longint h, cs, sn;
			logic [31:0] p;
			logic top;
			n = segments();
			last = 4 * n + 1;
			v = '{default: '0};
			if (k > last) begin
				v.err = 1'b1;
				return v;
			end
			h = (len + 1) >> 1;
			top = (k <= 2 * n);
			v.py = POS_W'(top ? h : -h);
			v.ny = NRM_W'(top ? NORM_ONE : -NORM_ONE);
			if (k != 0 && k != last) begin
				seg = (k - 1) / n;
				j = (k - 1) % n;
				r = top ? top_r : bot_r;
				p = 32'(((j << 32) + n / 2) / n);
				cs = turn_sine(p + 32'h4000_0000);
				sn = turn_sine(p);
				v.px = POS_W'(round_scaled(cs, r, 30));
				v.pz = POS_W'(round_scaled(sn, r, 30));
				if (seg == 1 || seg == 2) begin
					v.ny = '0;
					if (r != 0) begin
						v.nx = NRM_W'(round_scaled(cs, slope_factor(), 46));
						v.nz = NRM_W'(round_scaled(sn, slope_factor(), 46));
					end
				end
			end
			v.r = COLOR_W'(cr); v.g = COLOR_W'(cg); v.b = COLOR_W'(cb);
			v.last = (k == last);
			return v;
		endfunction

		function void note_index(longint unsigned k);
			pending_vertices.push_back(vertex_at(k));
		endfunction

		function void compare(string name, longint e, longint a);
			if (e != a) begin
				$error("%s: expected %0d, got %0d", name, e, a);
				mismatches++;
			end
		endfunction

		function void check_vertex(vertex_t a);
			vertex_t e;
			if (pending_vertices.size() == 0) begin
				$error("unexpected output item");
				mismatches++;
				return;
			end
			e = pending_vertices.pop_front();
			compare("pos_x", e.px, a.px);
			compare("pos_y", e.py, a.py);
			compare("pos_z", e.pz, a.pz);
			compare("normal_x", e.nx, a.nx);
			compare("normal_y", e.ny, a.ny);
			compare("normal_z", e.nz, a.nz);
			compare("red", e.r, a.r);
			compare("green", e.g, a.g);
			compare("blue", e.b, a.b);
			compare("index_error", e.err, a.err);
			compare("last_vertex", e.last, a.last);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [IDX_W-1:0] vertex_index;
	logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
	logic signed [NRM_W-1:0] normal_x, normal_y, normal_z;
	logic [COLOR_W-1:0] red, green, blue;
	logic index_error, last_vertex;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	vertex_scoreboard sb = new();
	bit quiet;          // no idling on either side
	int idle_cycles;

	frustum_mesh_vertex_generator dut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function int gap_length();
		int roll;
		if (quiet) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver stall in stretches
	int stall_left;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= (gap_length() > 0);
			stall_left <= gap_length();
		end
	end

	always @(posedge clk) begin
		vertex_t a;
		if (arst_n && out_valid && !out_stall) begin
			a = '{pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
				red, green, blue, index_error, last_vertex};
			sb.check_vertex(a);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_index(logic [IDX_W-1:0] k);
		int g;
		@(negedge clk);
		in_valid <= 1'b1;
		vertex_index <= k;
		do @(posedge clk); while (in_stall);
		sb.note_index(k);
		g = gap_length();
		if (g > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_vertices.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		sb.write_reg(idx, d);
	endtask

	// upper data bits are junk on the narrow registers, which must mask them
	task automatic program_shape(int res, int tr, int br, int ht, int r, int g, int b);
		write_reg(REG_RESOLUTION, CFG_DATA_W'({$urandom_range(0, 127), 9'd0} | res));
		write_reg(REG_TOP_RADIUS, CFG_DATA_W'(tr));
		write_reg(REG_BOTTOM_RADIUS, CFG_DATA_W'(br));
		write_reg(REG_HEIGHT, CFG_DATA_W'(ht));
		write_reg(REG_RED, {8'($urandom), 8'(r)});
		write_reg(REG_GREEN, {8'($urandom), 8'(g)});
		write_reg(REG_BLUE, {8'($urandom), 8'(b)});
		write_reg(REG_SPARE, CFG_DATA_W'($urandom));
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic random_indices(int count);
		longint unsigned last;
		int roll;
		last = 4 * sb.segments() + 1;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 80) send_index(IDX_W'($urandom_range(0, 32'(last))));
			else if (roll < 90)
				send_index((last + roll - 80 > 2047) ? IDX_W'(2047) : IDX_W'(last + roll - 80));
			else send_index(IDX_W'($urandom_range(0, 2047)));
		end
	endtask

	initial begin
		int directed_idx[];
		directed_idx = '{0, 1, 5, 9, 16, 17, 21, 32, 33, 41, 48, 49, 57,
			64, 65, 66, 1024, 2047};
		arst_n = 1'b0;
		in_valid = 1'b0;
		vertex_index = '0;
		out_stall = 1'b0;
		stall_left = 0;
		cfg_write = 1'b0;
		cfg_index = REG_RESOLUTION;
		cfg_data = '0;
		idle_cycles = 0;
		quiet = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_idx[i]) send_index(IDX_W'(directed_idx[i]));
		random_indices(40);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: program_shape(1, 0, 65535, 1, 0, 0, 0);
				1: program_shape(256, 65535, 0, 65535, 255, 255, 255);
				2: program_shape(0, 300, 300, 0, 17, 34, 51);       // flat, equal radii
				3: program_shape(3, 1234, 800, 0, 1, 2, 3);         // flat, unequal radii
				4: program_shape(511, 0, 0, 100, 128, 64, 32);      // resolution clamps
				default: program_shape($urandom_range(1, 64), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(1, 65535),
					$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
			endcase
			quiet = (ph % 4 == 3);
			for (int k = 0; k < 6; k++) send_index(IDX_W'(k));
			random_indices(40);
			drain();
		end

		if (sb.mismatches == 0 && sb.pending_vertices.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
